// ===== rtl/core/gss_pkg.sv =====
package gss_pkg;

	// Request bytes
	localparam logic [7:0] REQ_UP   = 8'h0F;
	localparam logic [7:0] REQ_DOWN = 8'hF0;

	// Actuator start commands
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_PUSH = 2'd1;
	localparam logic [1:0] ACT_PULL = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE            = 3'd0;
	localparam logic [2:0] ERR_UP_TIMEOUT      = 3'd1;
	localparam logic [2:0] ERR_DOWN_TIMEOUT    = 3'd2;
	localparam logic [2:0] ERR_CLUTCH_TIMEOUT  = 3'd3;
	localparam logic [2:0] ERR_NEUTRAL_TIMEOUT = 3'd4;
	localparam logic [2:0] ERR_WRONG_GEAR      = 3'd5;
	localparam logic [2:0] ERR_SERVO_OFFLINE   = 3'd6;

	// Reported stage codes
	localparam logic [2:0] CODE_START     = 3'd0;
	localparam logic [2:0] CODE_GEARING   = 3'd1;
	localparam logic [2:0] CODE_CLUTCHING = 3'd2;
	localparam logic [2:0] CODE_ERROR     = 3'd3;
	localparam logic [2:0] CODE_FINISHED  = 3'd4;

	// Gears with a special meaning
	localparam logic [2:0] GEAR_NEUTRAL = 3'd0;
	localparam logic [2:0] GEAR_FIRST   = 3'd1;
	localparam logic [2:0] GEAR_MAX     = 3'd7;

	// Configuration register indexes and reset values
	localparam int unsigned    ADDR_W           = 4;
	localparam logic [1:0]     REG_TIMEOUT      = 2'd0;
	localparam logic [1:0]     REG_THRESHOLD    = 2'd1;
	localparam logic [1:0]     REG_TOP_GEAR     = 2'd2;
	localparam logic [1:0]     REG_PERIOD       = 2'd3;
	localparam logic [15:0]    RST_TIMEOUT      = 16'd3000;
	localparam logic [7:0]     RST_THRESHOLD    = 8'd14;
	localparam logic [2:0]     RST_TOP_GEAR     = 3'd5;
	localparam logic [9:0]     RST_PERIOD       = 10'd30;

	typedef enum logic [4:0] {
		ST_START     = 5'b00001,
		ST_GEARING   = 5'b00010,
		ST_CLUTCHING = 5'b00100,
		ST_ERROR     = 5'b01000,
		ST_FINISHED  = 5'b10000
	} stage_t;

	typedef enum logic [4:0] {
		MODE_UP           = 5'b00001,
		MODE_DOWN         = 5'b00010,
		MODE_N_ENGAGE     = 5'b00100,
		MODE_N_DISENGAGE  = 5'b01000,
		MODE_NOTHING      = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [15:0] shift_timeout_ms;
		logic [7:0]  pressure_threshold;
		logic [2:0]  top_gear;
		logic [9:0]  report_period_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  request_byte;
		logic [2:0]  sensed_gear;
		logic [7:0]  clutch_pressure;
		logic [31:0] now_ms;
		logic        servo_online;
	} item_t;

	typedef struct packed {
		logic [1:0] shift_start;
		logic       shift_stop;
		logic       clutch_engage;
		logic       clutch_release;
		logic [2:0] error_code;
		logic [2:0] stage_now;
		logic       report_valid;
		logic [2:0] report_gear;
		logic [7:0] report_pressure;
	} result_t;

	typedef struct packed {
		stage_t      stage;
		mode_t       active_mode;
		logic [2:0]  target_gear;
		logic [31:0] shift_start_time;
		logic [31:0] last_report_time;
	} state_t;

	function automatic logic [2:0] stage_code(stage_t s);
		logic [2:0] c;
		case (s)
			ST_START:     c = CODE_START;
			ST_GEARING:   c = CODE_GEARING;
			ST_CLUTCHING: c = CODE_CLUTCHING;
			ST_ERROR:     c = CODE_ERROR;
			ST_FINISHED:  c = CODE_FINISHED;
			default:      c = CODE_START;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/gss_if.sv =====
interface gss_item_if;
	logic        valid;
	logic        ready;
	logic [7:0]  request_byte;
	logic [2:0]  sensed_gear;
	logic [7:0]  clutch_pressure;
	logic [31:0] now_ms;
	logic        servo_online;

	modport source(output valid, request_byte, sensed_gear, clutch_pressure, now_ms,
		servo_online, input ready);
	modport sink(input valid, request_byte, sensed_gear, clutch_pressure, now_ms,
		servo_online, output ready);
endinterface

interface gss_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] shift_start;
	logic       shift_stop;
	logic       clutch_engage;
	logic       clutch_release;
	logic [2:0] error_code;
	logic [2:0] stage_now;
	logic       report_valid;
	logic [2:0] report_gear;
	logic [7:0] report_pressure;

	modport source(output valid, shift_start, shift_stop, clutch_engage, clutch_release,
		error_code, stage_now, report_valid, report_gear, report_pressure, input ready);
	modport sink(input valid, shift_start, shift_stop, clutch_engage, clutch_release,
		error_code, stage_now, report_valid, report_gear, report_pressure, output ready);
endinterface

// ===== rtl/core/gss_step.sv =====
module gss_step (
	input  gss_pkg::state_t  cur,
	input  gss_pkg::cfg_t    cfg,
	input  gss_pkg::item_t   item,
	output gss_pkg::state_t  nxt,
	output gss_pkg::result_t res
);

	gss_pkg::stage_t stg;
	gss_pkg::mode_t  mode;
	logic [2:0]      tgt;
	logic [31:0]     sst;
	logic [31:0]     rep_age;
	logic [1:0]      act;
	logic            stop;
	logic            engage;
	logic            release_cmd;
	logic [2:0]      err;
	logic            releases;
	logic            is_up;
	logic            is_down;
	logic            pres_ok;
	logic            to;
	logic [2:0]      gear;

	always_comb begin
		gear        = item.sensed_gear;
		is_up       = item.request_byte == gss_pkg::REQ_UP;
		is_down     = item.request_byte == gss_pkg::REQ_DOWN;
		pres_ok     = item.clutch_pressure >= cfg.pressure_threshold;
		stg         = cur.stage;
		mode        = cur.active_mode;
		tgt         = cur.target_gear;
		sst         = cur.shift_start_time;
		act         = gss_pkg::ACT_NONE;
		stop        = 1'b0;
		engage      = 1'b0;
		release_cmd = 1'b0;
		err         = gss_pkg::ERR_NONE;
		releases    = 1'b0;

		// Take a new request only while no shift is under way
		if (stg != gss_pkg::ST_GEARING && stg != gss_pkg::ST_CLUTCHING) begin
			if (is_up && gear != cfg.top_gear && gear < gss_pkg::GEAR_MAX) begin
				tgt  = gear + 3'd1;
				mode = gss_pkg::MODE_UP;
				stg  = gss_pkg::ST_START;
			end
			if (is_down && gear != gss_pkg::GEAR_NEUTRAL) begin
				tgt  = gear - 3'd1;
				mode = gss_pkg::MODE_DOWN;
				stg  = gss_pkg::ST_START;
			end
			if (is_down && gear == gss_pkg::GEAR_FIRST) begin
				mode = gss_pkg::MODE_N_ENGAGE;
				stg  = gss_pkg::ST_START;
			end
			if (is_up && gear == gss_pkg::GEAR_NEUTRAL) begin
				mode = gss_pkg::MODE_N_DISENGAGE;
				stg  = gss_pkg::ST_START;
			end
		end

		// Every active mode stamps the shift start time on its start stage
		if (stg == gss_pkg::ST_START && mode != gss_pkg::MODE_NOTHING) begin
			sst = item.now_ms;
		end
		to = (item.now_ms - sst) >= {16'd0, cfg.shift_timeout_ms};

		// Advance the stage machine of the active mode
		case (mode)
			gss_pkg::MODE_UP: begin
				if (stg == gss_pkg::ST_START) begin
					act = gss_pkg::ACT_PUSH;
					stg = gss_pkg::ST_GEARING;
				end
				if (stg == gss_pkg::ST_GEARING) begin
					if (gear == tgt) begin
						stg = gss_pkg::ST_FINISHED;
					end else if (to) begin
						err = gss_pkg::ERR_UP_TIMEOUT;
						stg = gss_pkg::ST_ERROR;
					end
				end
			end
			gss_pkg::MODE_DOWN: begin
				releases = 1'b1;
				if (stg == gss_pkg::ST_START) begin
					engage = 1'b1;
					stg    = gss_pkg::ST_GEARING;
				end
				if (stg == gss_pkg::ST_GEARING && pres_ok) begin
					stg = gss_pkg::ST_CLUTCHING;
					act = gss_pkg::ACT_PULL;
				end
				if (gear == tgt) begin
					stg = gss_pkg::ST_FINISHED;
				end
				if (stg != gss_pkg::ST_FINISHED && to) begin
					err = (stg == gss_pkg::ST_CLUTCHING) ? gss_pkg::ERR_CLUTCH_TIMEOUT
						: gss_pkg::ERR_DOWN_TIMEOUT;
					stg = gss_pkg::ST_ERROR;
				end
			end
			gss_pkg::MODE_N_ENGAGE: begin
				if (stg == gss_pkg::ST_START) begin
					act = gss_pkg::ACT_PUSH;
					stg = gss_pkg::ST_GEARING;
				end
				if (stg == gss_pkg::ST_GEARING) begin
					if (gear == gss_pkg::GEAR_FIRST) begin
						stg = gss_pkg::ST_FINISHED;
					end else if (to) begin
						err = gss_pkg::ERR_NEUTRAL_TIMEOUT;
						stg = gss_pkg::ST_ERROR;
					end else if (gear > gss_pkg::GEAR_FIRST) begin
						err = gss_pkg::ERR_WRONG_GEAR;
						stg = gss_pkg::ST_ERROR;
					end
				end
			end
			gss_pkg::MODE_N_DISENGAGE: begin
				releases = 1'b1;
				if (stg == gss_pkg::ST_START) begin
					engage = 1'b1;
					if (item.servo_online) begin
						stg = gss_pkg::ST_GEARING;
					end else begin
						err = gss_pkg::ERR_SERVO_OFFLINE;
						stg = gss_pkg::ST_ERROR;
					end
				end
				if (stg == gss_pkg::ST_GEARING && pres_ok) begin
					stg = gss_pkg::ST_CLUTCHING;
					act = gss_pkg::ACT_PULL;
				end
				if (stg == gss_pkg::ST_CLUTCHING) begin
					if (gear == gss_pkg::GEAR_FIRST) begin
						stg = gss_pkg::ST_FINISHED;
					end else if (to) begin
						err = gss_pkg::ERR_NEUTRAL_TIMEOUT;
						stg = gss_pkg::ST_ERROR;
					end else if (gear > gss_pkg::GEAR_FIRST) begin
						err = gss_pkg::ERR_WRONG_GEAR;
						stg = gss_pkg::ST_ERROR;
					end
				end
			end
			default: begin
			end
		endcase

		// Close out a finished or failed shift
		if (mode != gss_pkg::MODE_NOTHING &&
		    (stg == gss_pkg::ST_FINISHED || stg == gss_pkg::ST_ERROR)) begin
			stop        = 1'b1;
			release_cmd = releases;
			mode        = gss_pkg::MODE_NOTHING;
		end

		// Periodic gear and pressure report
		rep_age              = item.now_ms - cur.last_report_time;
		res.report_valid     = rep_age >= {22'd0, cfg.report_period_ms};
		res.report_gear      = res.report_valid ? gear : 3'd0;
		res.report_pressure  = res.report_valid ? item.clutch_pressure : 8'd0;
		nxt.last_report_time = res.report_valid ? item.now_ms : cur.last_report_time;

		nxt.stage            = stg;
		nxt.active_mode      = mode;
		nxt.target_gear      = tgt;
		nxt.shift_start_time = sst;

		res.shift_start      = act;
		res.shift_stop       = stop;
		res.clutch_engage    = engage;
		res.clutch_release   = release_cmd;
		res.error_code       = err;
		res.stage_now        = gss_pkg::stage_code(stg);
	end

endmodule

// ===== rtl/core/gear_shift_sequencer_unit.sv =====
// Path: an accepted transaction is held in the input register and its result is then
// shown from the result register (input register, then result register).
// Throughput: one transaction per cycle unless result.ready stalls; the shift state is
// updated in the single step between the two registers, so items follow back to back.
// Reset (arst_n low, asynchronous): stage start, no active mode, target gear and
// time stamps zero, configuration at its defaults, both registers empty.
module gear_shift_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	gss_item_if.sink                        item,
	gss_result_if.source                    result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gss_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	gss_pkg::cfg_t    cfg_q;
	gss_pkg::state_t  state_q;
	gss_pkg::state_t  state_nxt;
	gss_pkg::item_t   item_s1;
	gss_pkg::result_t res_nxt;
	gss_pkg::result_t res_s2;
	logic             item_valid_s1;
	logic             res_valid_s2;
	logic             advance;
	logic             fire;
	logic             accept;
	logic             cfg_wr;
	logic [1:0]       reg_idx;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shift_timeout_ms   <= gss_pkg::RST_TIMEOUT;
			cfg_q.pressure_threshold <= gss_pkg::RST_THRESHOLD;
			cfg_q.top_gear           <= gss_pkg::RST_TOP_GEAR;
			cfg_q.report_period_ms   <= gss_pkg::RST_PERIOD;
		end else if (cfg_wr) begin
			case (reg_idx)
				gss_pkg::REG_TIMEOUT:   cfg_q.shift_timeout_ms   <= pwdata[15:0];
				gss_pkg::REG_THRESHOLD: cfg_q.pressure_threshold <= pwdata[7:0];
				gss_pkg::REG_TOP_GEAR:  cfg_q.top_gear           <= pwdata[2:0];
				gss_pkg::REG_PERIOD:    cfg_q.report_period_ms   <= pwdata[9:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gss_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg_q.shift_timeout_ms};
			gss_pkg::REG_THRESHOLD: prdata = {24'd0, cfg_q.pressure_threshold};
			gss_pkg::REG_TOP_GEAR:  prdata = {29'd0, cfg_q.top_gear};
			gss_pkg::REG_PERIOD:    prdata = {22'd0, cfg_q.report_period_ms};
			default:                prdata = 32'd0;
		endcase
	end

	// Handshake: the result register frees the input register when it drains
	assign advance    = !res_valid_s2 || result.ready;
	assign item.ready = !item_valid_s1 || advance;
	assign accept     = item.valid && item.ready;
	assign fire       = item_valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.request_byte    <= item.request_byte;
			item_s1.sensed_gear     <= item.sensed_gear;
			item_s1.clutch_pressure <= item.clutch_pressure;
			item_s1.now_ms          <= item.now_ms;
			item_s1.servo_online    <= item.servo_online;
		end
	end

	// One sequencing step per transaction
	gss_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.stage            <= gss_pkg::ST_START;
			state_q.active_mode      <= gss_pkg::MODE_NOTHING;
			state_q.target_gear      <= 3'd0;
			state_q.shift_start_time <= 32'd0;
			state_q.last_report_time <= 32'd0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid           = res_valid_s2;
	assign result.shift_start     = res_s2.shift_start;
	assign result.shift_stop      = res_s2.shift_stop;
	assign result.clutch_engage   = res_s2.clutch_engage;
	assign result.clutch_release  = res_s2.clutch_release;
	assign result.error_code      = res_s2.error_code;
	assign result.stage_now       = res_s2.stage_now;
	assign result.report_valid    = res_s2.report_valid;
	assign result.report_gear     = res_s2.report_gear;
	assign result.report_pressure = res_s2.report_pressure;

endmodule
